FILE: design/mrw_pkg.sv
// shared types and constants for the miller-rabin witness test core
// no dependencies
package mrw_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH + 1);

  typedef logic [WIDTH-1:0] word_t;

  typedef enum logic [1:0] {
    VERDICT_PRIME   = 2'd0,
    VERDICT_FERMAT  = 2'd1,
    VERDICT_ROOT    = 2'd2,
    VERDICT_INVALID = 2'd3
  } verdict_t;

  typedef struct packed {
    logic  start;
    word_t x;
    word_t y;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    word_t res;
  } mul_rsp_t;

endpackage

FILE: design/mrw_addmod.sv
// modular adder: (x + y) mod m for x, y < m
// depends on mrw_pkg
module mrw_addmod (
  input  mrw_pkg::word_t x,
  input  mrw_pkg::word_t y,
  input  mrw_pkg::word_t m,
  output mrw_pkg::word_t sum
);

  logic [mrw_pkg::WIDTH:0] s;
  logic [mrw_pkg::WIDTH:0] d;

  always_comb begin
    s = {1'b0, x} + {1'b0, y};
    d = s - {1'b0, m};
    if (s >= {1'b0, m}) begin
      sum = d[mrw_pkg::WIDTH-1:0];
    end else begin
      sum = s[mrw_pkg::WIDTH-1:0];
    end
  end

endmodule

FILE: design/mrw_mulmod.sv
// bit-serial modular multiplier built on one shared modular adder
// depends on mrw_pkg and mrw_addmod
module mrw_mulmod (
  input  logic              clk,
  input  logic              rst_n,
  input  mrw_pkg::word_t    m,
  input  mrw_pkg::mul_req_t req,
  output mrw_pkg::mul_rsp_t rsp
);

  logic           run_r, run_nxt;
  logic           phase_r, phase_nxt;
  mrw_pkg::word_t x_r, x_nxt;
  mrw_pkg::word_t y_r, y_nxt;
  mrw_pkg::word_t acc_r, acc_nxt;
  mrw_pkg::word_t add_a;
  mrw_pkg::word_t add_s;
  logic           fin;

  assign fin   = run_r && (y_r == '0);
  // doubling uses x + x whenever the accumulate step is skipped or done
  assign add_a = (phase_r || !y_r[0]) ? x_r : acc_r;

  mrw_addmod u_add (
    .x   (add_a),
    .y   (x_r),
    .m   (m),
    .sum (add_s)
  );

  always_comb begin
    run_nxt   = run_r;
    phase_nxt = phase_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    acc_nxt   = acc_r;
    if (req.start && !run_r) begin
      run_nxt   = 1'b1;
      phase_nxt = 1'b0;
      x_nxt     = req.x;
      y_nxt     = req.y;
      acc_nxt   = '0;
    end else if (fin) begin
      run_nxt = 1'b0;
    end else if (run_r) begin
      if (!phase_r && y_r[0]) begin
        acc_nxt   = add_s;
        phase_nxt = 1'b1;
      end else begin
        // double step
        x_nxt     = add_s;
        y_nxt     = y_r >> 1;
        phase_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      run_r   <= run_nxt;
      phase_r <= phase_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
  end

  assign rsp.done = fin;
  assign rsp.res  = acc_r;

endmodule

FILE: design/miller_rabin_witness_test_core.sv
// miller-rabin single-base witness test, top level and sequencer
// depends on mrw_pkg, mrw_mulmod, mrw_addmod
// an invalid candidate is reported in the cycle after it is accepted; otherwise one
// base reduction plus up to about 2*WIDTH modular products on the shared multiplier;
// one item at a time, busy high meanwhile
// reset is synchronous active low and clears the sequencer and the result strobe
module miller_rabin_witness_test_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_candidate,
  input  logic [31:0] in_base,
  output logic        out_valid,
  output logic [1:0]  out_verdict,
  output logic        out_probable_prime
);

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b00000000001,
    ST_RED    = 11'b00000000010,
    ST_RED_W  = 11'b00000000100,
    ST_SHIFT  = 11'b00000001000,
    ST_EXP    = 11'b00000010000,
    ST_EXP_SQ = 11'b00000100000,
    ST_EXP_WR = 11'b00001000000,
    ST_EXP_WB = 11'b00010000000,
    ST_SQR    = 11'b00100000000,
    ST_SQR_W  = 11'b01000000000,
    ST_DONE   = 11'b10000000000
  } state_t;

  state_t                   state_r, state_nxt;
  mrw_pkg::word_t           n_r, n_nxt;
  mrw_pkg::word_t           nm1_r, nm1_nxt;
  mrw_pkg::word_t           e_r, e_nxt;
  mrw_pkg::word_t           r_r, r_nxt;
  mrw_pkg::word_t           b_r, b_nxt;
  mrw_pkg::word_t           x_r, x_nxt;
  logic [mrw_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                     root_r, root_nxt;
  logic                     ov_r, ov_nxt;
  mrw_pkg::verdict_t        verdict_r, verdict_nxt;
  mrw_pkg::word_t           cand_w;
  mrw_pkg::word_t           base_w;
  mrw_pkg::mul_req_t        mreq;
  mrw_pkg::mul_rsp_t        mrsp;
  logic                     accept;

  assign cand_w = mrw_pkg::WIDTH'(in_candidate);
  assign base_w = mrw_pkg::WIDTH'(in_base);
  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  mrw_mulmod u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .m     (n_r),
    .req   (mreq),
    .rsp   (mrsp)
  );

  always_comb begin
    state_nxt   = state_r;
    n_nxt       = n_r;
    nm1_nxt     = nm1_r;
    e_nxt       = e_r;
    r_nxt       = r_r;
    b_nxt       = b_r;
    x_nxt       = x_r;
    cnt_nxt     = cnt_r;
    root_nxt    = root_r;
    ov_nxt      = 1'b0;
    verdict_nxt = verdict_r;
    mreq.start  = 1'b0;
    mreq.x      = r_r;
    mreq.y      = b_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          n_nxt    = cand_w;
          nm1_nxt  = cand_w - mrw_pkg::word_t'(1);
          e_nxt    = cand_w - mrw_pkg::word_t'(1);
          b_nxt    = base_w;
          cnt_nxt  = '0;
          root_nxt = 1'b0;
          if (cand_w < mrw_pkg::word_t'(2)) begin
            ov_nxt      = 1'b1;
            verdict_nxt = mrw_pkg::VERDICT_INVALID;
          end else begin
            state_nxt = ST_RED;
          end
        end
      end
      ST_RED: begin
        // base mod n as 1 * base
        mreq.start = 1'b1;
        mreq.x     = mrw_pkg::word_t'(1);
        mreq.y     = b_r;
        state_nxt  = ST_RED_W;
      end
      ST_RED_W: begin
        if (mrsp.done) begin
          b_nxt     = mrsp.res;
          r_nxt     = mrw_pkg::word_t'(1);
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (e_r[0]) begin
          state_nxt = ST_EXP;
        end else begin
          e_nxt   = e_r >> 1;
          cnt_nxt = cnt_r + mrw_pkg::CNT_W'(1);
        end
      end
      ST_EXP: begin
        if (e_r == '0) begin
          x_nxt     = r_r;
          state_nxt = ST_SQR;
        end else if (e_r[0]) begin
          mreq.start = 1'b1;
          mreq.x     = r_r;
          mreq.y     = b_r;
          state_nxt  = ST_EXP_WR;
        end else begin
          state_nxt = ST_EXP_SQ;
        end
      end
      ST_EXP_WR: begin
        if (mrsp.done) begin
          r_nxt     = mrsp.res;
          state_nxt = ST_EXP_SQ;
        end
      end
      ST_EXP_SQ: begin
        mreq.start = 1'b1;
        mreq.x     = b_r;
        mreq.y     = b_r;
        state_nxt  = ST_EXP_WB;
      end
      ST_EXP_WB: begin
        if (mrsp.done) begin
          b_nxt     = mrsp.res;
          e_nxt     = e_r >> 1;
          state_nxt = ST_EXP;
        end
      end
      ST_SQR: begin
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          mreq.start = 1'b1;
          mreq.x     = x_r;
          mreq.y     = x_r;
          state_nxt  = ST_SQR_W;
        end
      end
      ST_SQR_W: begin
        if (mrsp.done) begin
          if (mrsp.res == mrw_pkg::word_t'(1) && x_r != mrw_pkg::word_t'(1)
              && x_r != nm1_r) begin
            root_nxt = 1'b1;
          end
          x_nxt     = mrsp.res;
          cnt_nxt   = cnt_r - mrw_pkg::CNT_W'(1);
          state_nxt = ST_SQR;
        end
      end
      ST_DONE: begin
        ov_nxt = 1'b1;
        if (x_r != mrw_pkg::word_t'(1)) begin
          verdict_nxt = mrw_pkg::VERDICT_FERMAT;
        end else if (root_r) begin
          verdict_nxt = mrw_pkg::VERDICT_ROOT;
        end else begin
          verdict_nxt = mrw_pkg::VERDICT_PRIME;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    n_r       <= n_nxt;
    nm1_r     <= nm1_nxt;
    e_r       <= e_nxt;
    r_r       <= r_nxt;
    b_r       <= b_nxt;
    x_r       <= x_nxt;
    cnt_r     <= cnt_nxt;
    root_r    <= root_nxt;
    verdict_r <= verdict_nxt;
  end

  assign out_valid          = ov_r;
  assign out_verdict        = verdict_r;
  assign out_probable_prime = (verdict_r == mrw_pkg::VERDICT_PRIME);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && cand_w >= mrw_pkg::word_t'(2)) |=> busy)
    else $error("accepted candidate did not raise busy");

  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |=> (out_valid && !busy))
    else $error("finished item produced no result transfer");

  a_mul_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mrsp.done |-> (state_r == ST_RED_W || state_r == ST_EXP_WR
                   || state_r == ST_EXP_WB || state_r == ST_SQR_W))
    else $error("multiplier finished outside a wait state");

  a_invalid_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && cand_w < mrw_pkg::word_t'(2)) |=>
      (out_valid && out_verdict == mrw_pkg::VERDICT_INVALID))
    else $error("invalid candidate not reported");

endmodule

FILE: test/miller_rabin_witness_test_core_tb.sv
`timescale 1ns / 1ps
// testbench for miller_rabin_witness_test_core: directed and random candidate/base
// transfers checked against an in-bench modular arithmetic verdict predictor
// depends on mrw_pkg and design/miller_rabin_witness_test_core.sv
module miller_rabin_witness_test_core_tb;
  import mrw_pkg::*;

  typedef logic [2*WIDTH-1:0] dword_t;

  typedef struct {
    verdict_t verdict;
    logic     probable_prime;
  } verdict_exp_t;

  localparam int unsigned CYCLE_LIMIT = 10_000_000;
  localparam int unsigned DRAIN_CYCLES = 4 * WIDTH;
  localparam int NUM_RANDOM = 270;
  localparam int NUM_PSEUDO = 20;
  localparam word_t PSEUDOPRIMES [NUM_PSEUDO] = '{
    32'd561, 32'd1105, 32'd1729, 32'd2465, 32'd2821, 32'd6601, 32'd8911, 32'd10585,
    32'd15841, 32'd29341, 32'd41041, 32'd46657, 32'd62745, 32'd75361, 32'd101101,
    32'd2047, 32'd3277, 32'd4033, 32'd4681, 32'd8321
  };

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_candidate;
  logic [31:0] in_base;
  logic        out_valid;
  logic [1:0]  out_verdict;
  logic        out_probable_prime;

  verdict_exp_t pending_verdicts[$];
  verdict_exp_t oldest_verdict;
  int           err_count = 0;
  int unsigned  cycle_count = 0;
  bit           idle_en = 1'b1;

  miller_rabin_witness_test_core DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_candidate       (in_candidate),
    .in_base            (in_base),
    .out_valid          (out_valid),
    .out_verdict        (out_verdict),
    .out_probable_prime (out_probable_prime)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic word_t mod_product(word_t x, word_t y, word_t m);
    dword_t p;
    p = dword_t'(x) * dword_t'(y);
    p = p % dword_t'(m);
    return p[WIDTH-1:0];
  endfunction

  function automatic word_t mod_power(word_t b, word_t e, word_t m);
    word_t r;
    word_t sq;
    word_t ex;
    r = 1;
    sq = b % m;
    ex = e;
    while (ex != 0) begin
      if (ex[0]) begin
        r = mod_product(r, sq, m);
      end
      sq = mod_product(sq, sq, m);
      ex = ex >> 1;
    end
    return r;
  endfunction

  function automatic verdict_t witness_verdict(word_t n, word_t a);
    word_t nm1;
    word_t v;
    word_t ar;
    word_t x;
    word_t prev;
    int    u;
    if (n < 2) begin
      return VERDICT_INVALID;
    end
    nm1 = n - 1;
    v = nm1;
    u = 0;
    while (!v[0]) begin
      v = v >> 1;
      u++;
    end
    ar = a % n;
    if (mod_power(ar, nm1, n) != 1) begin
      return VERDICT_FERMAT;
    end
    x = mod_power(ar, v, n);
    for (int j = 1; j <= u; j++) begin
      prev = x;
      x = mod_product(x, x, n);
      if (x == 1 && prev != 1 && prev != nm1) begin
        return VERDICT_ROOT;
      end
    end
    return VERDICT_PRIME;
  endfunction

  // bases 2, 7 and 61 settle primality for every 32-bit value
  function automatic bit is_prime(word_t n);
    word_t bases [3];
    bases = '{32'd2, 32'd7, 32'd61};
    if (n < 2) begin
      return 1'b0;
    end
    foreach (bases[i]) begin
      if (bases[i] % n != 0 && witness_verdict(n, bases[i]) != VERDICT_PRIME) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic word_t random_prime();
    word_t n;
    do begin
      n = ($urandom >> $urandom_range(0, 27)) | 32'd1;
    end while (!is_prime(n));
    return n;
  endfunction

  task automatic send_candidate(input word_t cand, input word_t b);
    verdict_exp_t e;
    if (idle_en && $urandom_range(99) < 37) begin
      start <= 1'b0;
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(20, 300)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    start        <= 1'b1;
    in_candidate <= cand;
    in_base      <= b;
    do @(posedge clk); while (busy);
    e.verdict = witness_verdict(cand, b);
    e.probable_prime = (e.verdict == VERDICT_PRIME);
    pending_verdicts.push_back(e);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result: verdict %0d, probable_prime %0b",
               out_verdict, out_probable_prime);
        err_count++;
      end else begin
        oldest_verdict = pending_verdicts.pop_front();
        if (out_verdict !== oldest_verdict.verdict) begin
          $error("verdict: expected %0d, got %0d", oldest_verdict.verdict, out_verdict);
          err_count++;
        end
        if (out_probable_prime !== oldest_verdict.probable_prime) begin
          $error("probable_prime: expected %0b, got %0b",
                 oldest_verdict.probable_prime, out_probable_prime);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic test_invalid_candidate();
    send_candidate(32'd0, 32'd0);
    send_candidate(32'd1, 32'hFFFF_FFFF);
    send_candidate(32'd0, 32'hFFFF_FFFF);
    send_candidate(32'd1, 32'd0);
  endtask

  task automatic test_candidate_two();
    send_candidate(32'd2, 32'd1);
    send_candidate(32'd2, 32'd0);
    send_candidate(32'd2, 32'hFFFF_FFFF);
    send_candidate(32'd2, 32'hFFFF_FFFE);
  endtask

  task automatic test_base_multiple();
    send_candidate(32'd97, 32'd0);
    send_candidate(32'd97, 32'd291);
    send_candidate(32'hFFFF_FFFB, 32'hFFFF_FFFB);
    send_candidate(32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_even_candidate();
    send_candidate(32'd4, 32'd3);
    send_candidate(32'hFFFF_FFFE, 32'd5);
    send_candidate(32'd6, 32'hFFFF_FFFF);
  endtask

  task automatic test_root_and_prime();
    send_candidate(32'd561, 32'd2);
    send_candidate(32'd2047, 32'd2);
    send_candidate(32'd3, 32'd2);
    send_candidate(32'hFFFF_FFFB, 32'd2);
    send_candidate(32'hFFFF_FFFB, 32'hFFFF_FFFA);
    send_candidate(32'h7FFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_random_mix();
    word_t       n;
    word_t       b;
    int unsigned pick;
    int unsigned kmax;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      idle_en = !(i >= 100 && i < 160);
      pick = $urandom_range(99);
      b = $urandom;
      if (pick < 35) begin
        n = random_prime();
      end else if (pick < 50) begin
        n = PSEUDOPRIMES[$urandom_range(0, NUM_PSEUDO - 1)];
        if ($urandom_range(3) == 0) begin
          b = 32'd2;
        end
      end else if (pick < 65) begin
        n = $urandom;
      end else if (pick < 80) begin
        n = $urandom_range(0, 300);
        if ($urandom_range(1) == 0) begin
          b = $urandom_range(0, 600);
        end
      end else if (pick < 90) begin
        n = random_prime();
        kmax = 32'hFFFF_FFFF / n;
        case ($urandom_range(0, 4))
          0: b = 32'd0;
          1: b = 32'd1;
          2: b = n - 1;
          3: b = n * $urandom_range(0, kmax);
          default: b = n + 1;
        endcase
      end else begin
        n = ($urandom_range(3) == 0) ? 32'd2 : ($urandom & 32'hFFFF_FFFE);
      end
      send_candidate(n, b);
    end
  endtask

  task automatic wait_for_drain();
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_candidate <= '0;
    in_base      <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_invalid_candidate();
    test_candidate_two();
    test_base_multiple();
    test_even_candidate();
    test_root_and_prime();
    test_random_mix();
    wait_for_drain();
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
